[rtl/srb_pkg.sv]
`default_nettype none
package srb_pkg;

  localparam logic FUNC_PUT = 1'b0;
  localparam logic FUNC_GET = 1'b1;

  localparam logic [1:0] ST_PUT_OK   = 2'd0;
  localparam logic [1:0] ST_PUT_REJ  = 2'd1;
  localparam logic [1:0] ST_GOT_CHAR = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // most characters one get emits
  localparam int unsigned MAX_EMIT = 32;

  typedef struct packed {
    logic put;        // accepted put transfer
    logic get_start;  // accepted get transfer
    logic get_pop;    // accepted get with at least one string stored
    logic rd;         // read store at read pointer
    logic ev;         // evaluate the byte just read
  } cmd_t;

  typedef struct packed {
    logic total_zero; // no committed string
    logic byte_zero;  // byte just read is a terminator
    logic out_free;   // output register can load this cycle
  } sts_t;

endpackage
`default_nettype wire

[rtl/srb_ctrl.sv]
`default_nettype none
module srb_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          func_i,
  output logic               in_ready_o,
  input  wire srb_pkg::sts_t sts_i,
  output srb_pkg::cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EV   = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.put       = accept && (func_i == srb_pkg::FUNC_PUT);
    cmd_o.get_start = accept && (func_i == srb_pkg::FUNC_GET);
    cmd_o.get_pop   = cmd_o.get_start && !sts_i.total_zero;
    cmd_o.rd        = (state_q == S_RD);
    cmd_o.ev        = (state_q == S_EV) && sts_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.get_pop) state_d = S_RD;
      end
      S_RD: begin
        state_d = S_EV;
      end
      S_EV: begin
        // stop at the terminator, otherwise fetch the next byte
        if (cmd_o.ev) state_d = sts_i.byte_zero ? S_IDLE : S_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

[rtl/srb_dp.sv]
`default_nettype none
module srb_dp #(
  parameter int unsigned CAPACITY = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire srb_pkg::cmd_t cmd_i,
  output srb_pkg::sts_t      sts_o,
  input  wire logic [7:0]    char_in_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [1:0]         status_o,
  output logic [7:0]         char_out_o,
  output logic               final_item_o,
  output logic [5:0]         stored_strings_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = CW + 1;
  localparam logic [AW-1:0] LAST_POS = AW'(CAPACITY - 1);
  localparam logic [5:0] EMIT_MAX = 6'(srb_pkg::MAX_EMIT);
  localparam logic [5:0] EMIT_LAST = 6'(srb_pkg::MAX_EMIT - 1);

  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
    return (p == LAST_POS) ? '0 : p + AW'(1);
  endfunction

  logic [7:0]    mem [CAPACITY];
  logic [7:0]    rdata_q;

  logic [AW-1:0] wp_q, wp_d, rp_q, rp_d, swp_q, swp_d;
  logic [CW-1:0] used_q, used_d, pend_q, pend_d, total_q, total_d;
  logic          ovf_q, ovf_d;
  logic [7:0]    held_q, held_d;
  logic          held_v_q, held_v_d;
  logic [5:0]    n_q, n_d, n_after;

  logic          out_valid_q, load;
  logic [1:0]    status_q, status_d;
  logic [7:0]    char_q, char_d;
  logic          final_q, final_d;
  logic [5:0]    strings_q;

  logic          fit, mem_we, byte_zero, ev_emit;
  logic [SW-1:0] need;

  assign byte_zero = (rdata_q == 8'd0);
  assign need      = SW'(used_q) + SW'(pend_q) + SW'(1);
  assign fit       = !ovf_q && (need <= SW'(CAPACITY));
  assign mem_we    = cmd_i.put && fit;
  assign n_after   = n_q + 6'(held_v_q);
  assign ev_emit   = byte_zero ? (held_v_q || (n_q == '0)) : held_v_q;

  always_comb begin
    sts_o.total_zero = (total_q == '0);
    sts_o.byte_zero  = byte_zero;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_comb begin
    wp_d     = wp_q;
    rp_d     = rp_q;
    swp_d    = swp_q;
    used_d   = used_q;
    pend_d   = pend_q;
    total_d  = total_q;
    ovf_d    = ovf_q;
    held_d   = held_q;
    held_v_d = held_v_q;
    n_d      = n_q;
    load     = 1'b0;
    status_d = srb_pkg::ST_PUT_OK;
    char_d   = 8'd0;
    final_d  = 1'b1;

    if (cmd_i.put) begin
      load = 1'b1;
      if (!fit) begin
        ovf_d    = 1'b1;
        status_d = srb_pkg::ST_PUT_REJ;
        if (char_in_i == 8'd0) begin
          // drop the whole string and roll back
          pend_d = '0;
          ovf_d  = 1'b0;
          swp_d  = wp_q;
        end
      end else begin
        swp_d  = next_pos(swp_q);
        pend_d = pend_q + CW'(1);
        if (char_in_i == 8'd0) begin
          wp_d    = swp_d;
          used_d  = used_q + pend_q + CW'(1);
          total_d = total_q + CW'(1);
          pend_d  = '0;
        end
      end
    end

    if (cmd_i.get_start) begin
      if (cmd_i.get_pop) begin
        total_d  = total_q - CW'(1);
        held_v_d = 1'b0;
        n_d      = '0;
      end else begin
        load     = 1'b1;
        status_d = srb_pkg::ST_EMPTY;
      end
    end

    if (cmd_i.ev) begin
      rp_d     = next_pos(rp_q);
      used_d   = used_q - CW'(1);
      load     = ev_emit;
      status_d = srb_pkg::ST_GOT_CHAR;
      char_d   = held_v_q ? held_q : 8'd0;
      // a held character before another character is last only if it hits the cap
      final_d  = byte_zero ? 1'b1 : (n_q == EMIT_LAST);
      if (!byte_zero) begin
        held_d   = rdata_q;
        held_v_d = (n_after < EMIT_MAX);
        n_d      = n_after;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[swp_q] <= char_in_i;
    if (cmd_i.rd) rdata_q <= mem[rp_q];
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    if (load) begin
      status_q  <= status_d;
      char_q    <= char_d;
      final_q   <= final_d;
      strings_q <= 6'(total_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      rp_q        <= '0;
      swp_q       <= '0;
      used_q      <= '0;
      pend_q      <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      held_v_q    <= 1'b0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wp_q     <= wp_d;
      rp_q     <= rp_d;
      swp_q    <= swp_d;
      used_q   <= used_d;
      pend_q   <= pend_d;
      total_q  <= total_d;
      ovf_q    <= ovf_d;
      held_v_q <= held_v_d;
      n_q      <= n_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign char_out_o       = char_q;
  assign final_item_o     = final_q;
  assign stored_strings_o = strings_q;

endmodule
`default_nettype wire

[rtl/string_ring_buffer.sv]
// Byte ring buffer holding whole zero-terminated strings, oldest first.
// Input channel (in_valid_i/in_ready_o): func_i 0 puts char_in_i as the next
// character of the string being built, a zero character ends and commits it
// if every byte fit, else the whole string is dropped. func_i 1 pops the
// oldest committed string.
// Output channel (out_valid_o/out_ready_i): one result per put (stored or
// rejected), one per get of an empty buffer or empty string, otherwise one
// result per popped character (at most 32), final_item_o on the last one.
// Every result carries the count of committed strings.
// Timing: a put or an empty get is taken by a single handshake and its result is
// shown the next cycle; a put a cycle is sustained while results drain.
// A get walks every stored byte of the string, terminator included; each
// byte is a registered read of the store followed by a decide step that
// holds one character back to know which is last.
// Input is held off during a get. A stalled receiver holds the output
// register and, through it, all further progress.
// Reset empties the buffer at once; store contents are not cleared.
`default_nettype none
module string_ring_buffer #(
  parameter int unsigned CAPACITY = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       func_i,
  input  wire logic [7:0] char_in_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      status_o,
  output logic [7:0]      char_out_o,
  output logic            final_item_o,
  output logic [5:0]      stored_strings_o
);

  srb_pkg::cmd_t cmd;
  srb_pkg::sts_t sts;

  srb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srb_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .char_in_i        (char_in_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .char_out_o       (char_out_o),
    .final_item_o     (final_item_o),
    .stored_strings_o (stored_strings_o)
  );

  // a put answers in the next cycle with a single final result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (func_i == srb_pkg::FUNC_PUT)) |=>
      (out_valid_o && final_item_o &&
       ((status_o == srb_pkg::ST_PUT_OK) || (status_o == srb_pkg::ST_PUT_REJ))))
    else $error("put transfer did not produce its result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != srb_pkg::ST_GOT_CHAR)) |->
      ((char_out_o == 8'd0) && final_item_o))
    else $error("non-character result carries data or is not final");

  // no new input while a popped string is still being emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == srb_pkg::ST_GOT_CHAR) && !final_item_o) |-> !in_ready_o)
    else $error("input accepted in the middle of a get");

endmodule
`default_nettype wire
